// File: sv/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants of the multi-channel sonar ranger.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned GAP_W   = 24;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned LINES_W = 8;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned DIST_W  = 16;

  localparam logic [CNT_W-1:0] MAX_CHANNELS   = 4'd8;
  localparam logic [GAP_W-1:0] IDLE_GAP_RST   = 24'd100000;
  localparam logic [CNT_W-1:0] CHAN_COUNT_RST = 4'd6;

  // configuration register indexes
  localparam logic CFG_IDLE_GAP   = 1'b0;
  localparam logic CFG_CHAN_COUNT = 1'b1;

  typedef enum logic [2:0] {
    MAIN_IDLE = 3'b001,
    MAIN_TRIG = 3'b010,
    MAIN_ECHO = 3'b100
  } main_state_t;

  typedef enum logic [2:0] {
    SUB_IDLE = 3'b001,
    SUB_RISE = 3'b010,
    SUB_FALL = 3'b100
  } sub_state_t;

  typedef struct packed {
    logic [GAP_W-1:0] idle_gap_us;
    logic [CNT_W-1:0] channel_count;
  } cfg_t;

  typedef struct packed {
    logic [LINES_W-1:0] trigger_levels;
    logic               reading_valid;
    logic [CH_W-1:0]    reading_channel;
    logic [DIST_W-1:0]  distance;
  } res_t;

endpackage

// File: sv/msr_in_if.sv
// ----------------------------------------------------------------------------
// msr_in_if
// Poll tick channel: microsecond time and echo line levels.
// ----------------------------------------------------------------------------
interface msr_in_if;
  import msr_pkg::*;

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  now_us;
  logic [LINES_W-1:0] echo_levels;

  modport source (output valid, output now_us, output echo_levels, input ready);
  modport sink   (input valid, input now_us, input echo_levels, output ready);

endinterface

// File: sv/msr_out_if.sv
// ----------------------------------------------------------------------------
// msr_out_if
// Result channel: trigger drive and completed range readings.
// ----------------------------------------------------------------------------
interface msr_out_if;
  import msr_pkg::*;

  logic               valid;
  logic               ready;
  logic [LINES_W-1:0] trigger_levels;
  logic               reading_valid;
  logic [CH_W-1:0]    reading_channel;
  logic [DIST_W-1:0]  distance;

  modport source (output valid, output trigger_levels, output reading_valid,
                  output reading_channel, output distance, input ready);
  modport sink   (input valid, input trigger_levels, input reading_valid,
                  input reading_channel, input distance, output ready);

endinterface

// File: sv/msr_core.sv
// ----------------------------------------------------------------------------
// msr_core
// Trigger / echo sequencer state and the result of one poll tick.
// ----------------------------------------------------------------------------
module msr_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick,
  input  logic [msr_pkg::TIME_W-1:0]   now_us,
  input  logic [msr_pkg::LINES_W-1:0]  echo_levels,
  input  msr_pkg::cfg_t                cfg,
  output msr_pkg::res_t                res
);
  import msr_pkg::*;

  main_state_t        main_r, main_nxt;
  sub_state_t         trig_r, trig_nxt;
  sub_state_t         echo_r, echo_nxt;
  logic [TIME_W-1:0]  mark_r, mark_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [CH_W-1:0]    chan_r, chan_nxt;
  logic [LINES_W-1:0] trigger_r, trigger_nxt;

  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-3:0]  quarter;
  logic [LINES_W-1:0] chan_bit;
  logic [CNT_W-1:0]   eff_count;
  logic [CNT_W-1:0]   chan_inc;
  logic               echo_hi;

  assign elapsed  = now_us - mark_r;
  assign quarter  = elapsed[TIME_W-1:2];
  assign chan_bit = LINES_W'(1) << chan_r;
  assign echo_hi  = |(echo_levels & chan_bit);
  assign chan_inc = {1'b0, chan_r} + CNT_W'(1);

  // clamp the channel count into 1..MAX_CHANNELS
  always_comb begin
    if (cfg.channel_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (cfg.channel_count > MAX_CHANNELS) begin
      eff_count = MAX_CHANNELS;
    end else begin
      eff_count = cfg.channel_count;
    end
  end

  always_comb begin
    main_nxt    = main_r;
    trig_nxt    = trig_r;
    echo_nxt    = echo_r;
    mark_nxt    = mark_r;
    dist_nxt    = dist_r;
    chan_nxt    = chan_r;
    trigger_nxt = trigger_r;
    res         = '0;

    unique case (main_r)
      MAIN_IDLE: begin
        if (elapsed > {{(TIME_W-GAP_W){1'b0}}, cfg.idle_gap_us}) main_nxt = MAIN_TRIG;
      end
      MAIN_TRIG: begin
        unique case (trig_r)
          SUB_IDLE: trig_nxt = SUB_RISE;
          SUB_RISE: begin
            trigger_nxt = trigger_r | chan_bit;
            mark_nxt    = now_us;
            trig_nxt    = SUB_FALL;
          end
          SUB_FALL: begin
            // drop the pulse once time has moved on
            if (now_us != mark_r) begin
              trigger_nxt = trigger_r & ~chan_bit;
              trig_nxt    = SUB_IDLE;
              main_nxt    = MAIN_ECHO;
              echo_nxt    = SUB_IDLE;
            end
          end
          default: trig_nxt = SUB_IDLE;
        endcase
      end
      MAIN_ECHO: begin
        unique case (echo_r)
          SUB_IDLE: begin
            if (echo_hi) begin
              mark_nxt = now_us;
              echo_nxt = SUB_RISE;
            end
          end
          SUB_RISE: begin
            if (!echo_hi) begin
              dist_nxt = (quarter[TIME_W-3:DIST_W] != '0) ? '1 : quarter[DIST_W-1:0];
              echo_nxt = SUB_FALL;
            end
          end
          SUB_FALL: begin
            echo_nxt            = SUB_IDLE;
            main_nxt            = MAIN_IDLE;
            res.reading_valid   = 1'b1;
            res.reading_channel = chan_r;
            res.distance        = dist_r;
            chan_nxt            = (chan_inc >= eff_count) ? '0 : chan_inc[CH_W-1:0];
          end
          default: echo_nxt = SUB_IDLE;
        endcase
      end
      default: main_nxt = MAIN_IDLE;
    endcase

    res.trigger_levels = trigger_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r    <= MAIN_IDLE;
      trig_r    <= SUB_IDLE;
      echo_r    <= SUB_IDLE;
      mark_r    <= '0;
      dist_r    <= '0;
      chan_r    <= '0;
      trigger_r <= '0;
    end else if (tick) begin
      main_r    <= main_nxt;
      trig_r    <= trig_nxt;
      echo_r    <= echo_nxt;
      mark_r    <= mark_nxt;
      dist_r    <= dist_nxt;
      chan_r    <= chan_nxt;
      trigger_r <= trigger_nxt;
    end
  end

`ifndef SYNTH
  a_trigger_only_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (trigger_r != '0) |-> (main_r == MAIN_TRIG && trig_r == SUB_FALL))
    else $error("trigger driven outside the pulse phase");

  a_trigger_single_line: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(trigger_r) <= 1)
    else $error("more than one trigger line high");

  a_channel_steps_after_echo: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && chan_r != $past(chan_r)) |->
      ($past(main_r) == MAIN_ECHO && $past(echo_r) == SUB_FALL && $past(tick)))
    else $error("channel advanced outside reading completion");
`endif

endmodule

// File: sv/multi_channel_sonar_ranger_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_sonar_ranger_unit
// Sequencer for a rotation of trigger/echo ultrasonic range sensors.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one poll tick per request: the free-running microsecond
//   time and the echo line of every channel. out_res returns exactly one
//   result per tick: the trigger drive for all channels and, on the tick
//   that completes a measurement, the channel and its distance (echo width
//   in us divided by four, saturated at 16 bits).
//   cfg_we/cfg_addr/cfg_wdata write idle_gap_us (index 0) and channel_count
//   (index 1); write them only while no tick is in flight.
// Throughput and output register:
//   One tick per clock cycle while out_res is not stalled. A result appears
//   in the cycle after its tick is accepted, from the output register.
// Reset:
//   rst_n low returns the sequencer to idle on channel 0 with all triggers
//   low, mark time 0, and the registers at gap 100000 us and 6 channels.
// Stall:
//   While out_res is stalled the result holds and a new tick is accepted only
//   in the cycle the held result is taken.
// ----------------------------------------------------------------------------
module multi_channel_sonar_ranger_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  msr_in_if.sink                     in_req,
  msr_out_if.source                  out_res,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [msr_pkg::GAP_W-1:0]  cfg_wdata
);
  import msr_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic tick;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign tick         = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_gap_us   <= IDLE_GAP_RST;
      cfg_r.channel_count <= CHAN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDLE_GAP:   cfg_r.idle_gap_us   <= cfg_wdata;
        CFG_CHAN_COUNT: cfg_r.channel_count <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  msr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .now_us      (in_req.now_us),
    .echo_levels (in_req.echo_levels),
    .cfg         (cfg_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      res_r <= res;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.trigger_levels  = res_r.trigger_levels;
  assign out_res.reading_valid   = res_r.reading_valid;
  assign out_res.reading_channel = res_r.reading_channel;
  assign out_res.distance        = res_r.distance;

`ifndef SYNTH
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_reading_has_no_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.reading_valid) |-> (res_r.trigger_levels == '0))
    else $error("reading reported while a trigger is driven");
`endif

endmodule
